### rtl/gradient_colormap_generator_core_assert.svh
// assertion macros for the colormap core rtl
`ifndef GRADIENT_COLORMAP_GENERATOR_CORE_ASSERT_SVH
`define GRADIENT_COLORMAP_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define GCM_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcm assertion failed");

`define GCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcm assertion failed");

`else

`define GCM_ASSERT_IMPLIES(label, ante, cons)

`define GCM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/gcm_pkg.sv
package gcm_pkg;

  localparam int INDEX_BITS = 12;
  localparam int MAP_COUNT  = 4;
  localparam int SIZE_BITS  = 13;
  localparam int SEL_BITS   = 2;
  localparam int CHAN_BITS  = 8;
  localparam int PT_BITS    = 4;
  localparam int DIV_W      = 22;
  localparam int QUOT_BITS  = 8;
  localparam int SEG_STEPS  = 3;
  localparam int QUOT_STEPS = 8;
  localparam int PROD_W     = CHAN_BITS + SIZE_BITS;
  localparam int GRAD_PTS   = 9;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PALETTE_SIZE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_SELECT   = 2'd1;

  // red in [2], green in [1], blue in [0]
  typedef logic [2:0][CHAN_BITS-1:0] rgb_t;

  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_W-1:0]     dvs;
    logic [QUOT_BITS-1:0] quot;
    logic [SEL_BITS-1:0]  sel;
    logic [SIZE_BITS-1:0] dval;
    logic                 at_end;
  } gcm_div_t;

  localparam logic [PT_BITS-1:0] GRAD_LAST [4] = '{4'd5, 4'd5, 4'd1, 4'd8};

  localparam rgb_t GRAD_TBL [4][GRAD_PTS] = '{
    '{24'h000040, 24'h000080, 24'hC00000, 24'hFF8000, 24'hFFFF00, 24'hFFFFFF,
      24'h000000, 24'h000000, 24'h000000},
    '{24'h002040, 24'h004080, 24'hC00000, 24'hFF8000, 24'hFFFF00, 24'hFFFFFF,
      24'h000000, 24'h000000, 24'h000000},
    '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000},
    '{24'h000080, 24'h0000FF, 24'h0080FF, 24'h00FFFF, 24'h80FF80, 24'hFFFF00,
      24'hFF8000, 24'hFF0000, 24'h800000}
  };

  function automatic rgb_t gcm_point(input logic [SEL_BITS-1:0] sel,
                                     input logic [PT_BITS-1:0] k);
    rgb_t pt;
    if (int'(k) < GRAD_PTS) begin
      pt = GRAD_TBL[sel][k];
    end else begin
      pt = '0;
    end
    return pt;
  endfunction

endpackage

### rtl/gradient_colormap_generator_core.sv
// Palette color generator: each entry_index transaction yields one RGB color
// blended along the selected gradient. A new index is taken every cycle
// while the output is not stalled. Three division cells find the segment
// and remainder, three blend stages form the weighted sum, and eight
// division cells per channel produce the rounded 8-bit value. Backpressure
// on the output stalls the whole chain, so in_ready follows out_ready while
// the output holds a color. Configuration writes are always ready and must be
// issued only while no transaction is in flight.
`include "gradient_colormap_generator_core_assert.svh"

module gradient_colormap_generator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gcm_pkg::INDEX_BITS-1:0]       entry_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gcm_pkg::CHAN_BITS-1:0]        red,
  output logic [gcm_pkg::CHAN_BITS-1:0]        green,
  output logic [gcm_pkg::CHAN_BITS-1:0]        blue,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [gcm_pkg::SIZE_BITS-1:0]        cfg_data
);
  import gcm_pkg::*;

  logic [SIZE_BITS-1:0] dval;
  logic [SIZE_BITS-1:0] dval_next;
  logic [SEL_BITS-1:0]  msel;
  logic [SEL_BITS-1:0]  msel_next;
  logic [SEL_BITS-1:0]  sel_eff;
  logic [PT_BITS-1:0]   last;
  logic                 advance;

  gcm_div_t seg_st  [SEG_STEPS+1];
  logic     seg_vld [SEG_STEPS+1];

  logic                 blend_valid;
  gcm_div_t [2:0]       blend_out;

  gcm_div_t ch_st  [3][QUOT_STEPS+1];
  logic     ch_vld [3][QUOT_STEPS+1];

  assign cfg_ready = 1'b1;

  always_comb begin
    dval_next = dval;
    msel_next = msel;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PALETTE_SIZE: begin
          dval_next = (cfg_data < SIZE_BITS'(2)) ? SIZE_BITS'(1) : cfg_data - SIZE_BITS'(1);
        end
        CFG_MAP_SELECT: begin
          msel_next = cfg_data[SEL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dval <= SIZE_BITS'(255);
      msel <= '0;
    end else begin
      dval <= dval_next;
      msel <= msel_next;
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // segment division entry: p = index * (n - 1) over d
  always_comb begin
    sel_eff = (int'(msel) < MAP_COUNT) ? msel : '0;
    last    = GRAD_LAST[sel_eff];
    seg_st[0].rem    = DIV_W'(entry_index) * DIV_W'(last);
    seg_st[0].dvs    = DIV_W'(dval) << (SEG_STEPS - 1);
    seg_st[0].quot   = '0;
    seg_st[0].sel    = sel_eff;
    seg_st[0].dval   = dval;
    seg_st[0].at_end = DIV_W'(entry_index) >= DIV_W'(dval);
  end

  assign seg_vld[0] = in_valid;

  for (genvar i = 0; i < SEG_STEPS; i++) begin : g_seg
    gcm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (seg_vld[i]),
      .in_data   (seg_st[i]),
      .out_valid (seg_vld[i+1]),
      .out_data  (seg_st[i+1])
    );
  end

  gcm_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .seg_valid  (seg_vld[SEG_STEPS]),
    .seg_in     (seg_st[SEG_STEPS]),
    .chan_valid (blend_valid),
    .chan_out   (blend_out)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign ch_st[c][0]  = blend_out[c];
    assign ch_vld[c][0] = blend_valid;
    for (genvar i = 0; i < QUOT_STEPS; i++) begin : g_step
      gcm_div_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (advance),
        .in_valid  (ch_vld[c][i]),
        .in_data   (ch_st[c][i]),
        .out_valid (ch_vld[c][i+1]),
        .out_data  (ch_st[c][i+1])
      );
    end
  end

  assign out_valid = ch_vld[0][QUOT_STEPS] & ch_vld[1][QUOT_STEPS] & ch_vld[2][QUOT_STEPS];
  assign red       = ch_st[2][QUOT_STEPS].quot;
  assign green     = ch_st[1][QUOT_STEPS].quot;
  assign blue      = ch_st[0][QUOT_STEPS].quot;

  `GCM_ASSERT_NEXT(a_cfg_size,
    cfg_valid && cfg_index == CFG_PALETTE_SIZE && cfg_data >= SIZE_BITS'(2),
    dval == $past(cfg_data) - SIZE_BITS'(1))
  `GCM_ASSERT_IMPLIES(a_seg_rem,
    seg_vld[SEG_STEPS] && !seg_st[SEG_STEPS].at_end,
    seg_st[SEG_STEPS].rem < DIV_W'(seg_st[SEG_STEPS].dval))
  `GCM_ASSERT_IMPLIES(a_seg_range,
    seg_vld[SEG_STEPS] && !seg_st[SEG_STEPS].at_end,
    seg_st[SEG_STEPS].quot[PT_BITS-1:0] < GRAD_LAST[seg_st[SEG_STEPS].sel])
  `GCM_ASSERT_IMPLIES(a_red_rem,
    out_valid,
    ch_st[2][QUOT_STEPS].rem < (ch_st[2][QUOT_STEPS].dvs << 1))

endmodule

### rtl/gcm_div_cell.sv
module gcm_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  gcm_pkg::gcm_div_t in_data,
  output logic              out_valid,
  output gcm_pkg::gcm_div_t out_data
);
  import gcm_pkg::*;

  gcm_div_t data_next;
  logic     ge;

  // one restoring division step, divisor walks right one bit per cell
  always_comb begin
    ge = in_data.rem >= in_data.dvs;
    data_next = in_data;
    if (ge) begin
      data_next.rem = in_data.rem - in_data.dvs;
    end
    data_next.quot = {in_data.quot[QUOT_BITS-2:0], ge};
    data_next.dvs  = in_data.dvs >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/gcm_blend.sv
module gcm_blend (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    seg_valid,
  input  gcm_pkg::gcm_div_t       seg_in,
  output logic                    chan_valid,
  output gcm_pkg::gcm_div_t [2:0] chan_out
);
  import gcm_pkg::*;

  logic [PT_BITS-1:0]   last;
  logic [PT_BITS-1:0]   seg;
  logic [SIZE_BITS-1:0] rfrac;
  logic                 at_end;
  rgb_t                 a_next;
  rgb_t                 b_next;
  logic [SIZE_BITS-1:0] wgt_a_next;
  logic [SIZE_BITS-1:0] wgt_b_next;

  logic                 va;
  rgb_t                 a_pt;
  rgb_t                 b_pt;
  logic [SIZE_BITS-1:0] wgt_a;
  logic [SIZE_BITS-1:0] wgt_b;
  logic [SIZE_BITS-1:0] dval_a;

  logic                   vb;
  logic [2:0][PROD_W-1:0] prod_a;
  logic [2:0][PROD_W-1:0] prod_b;
  logic [SIZE_BITS-1:0]   dval_b;

  logic [2:0][PROD_W-1:0] sum;

  // pick end points; past the last segment both ends are the last point
  always_comb begin
    last   = GRAD_LAST[seg_in.sel];
    seg    = seg_in.quot[PT_BITS-1:0];
    rfrac  = seg_in.rem[SIZE_BITS-1:0];
    at_end = seg_in.at_end || (seg >= last);
    if (at_end) begin
      a_next     = gcm_point(seg_in.sel, last);
      b_next     = gcm_point(seg_in.sel, last);
      wgt_a_next = seg_in.dval;
      wgt_b_next = '0;
    end else begin
      a_next     = gcm_point(seg_in.sel, seg);
      b_next     = gcm_point(seg_in.sel, seg + 4'd1);
      wgt_a_next = seg_in.dval - rfrac;
      wgt_b_next = rfrac;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = prod_a[c] + prod_b[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va         <= 1'b0;
      vb         <= 1'b0;
      chan_valid <= 1'b0;
    end else if (en) begin
      va         <= seg_valid;
      vb         <= va;
      chan_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pt   <= a_next;
      b_pt   <= b_next;
      wgt_a  <= wgt_a_next;
      wgt_b  <= wgt_b_next;
      dval_a <= seg_in.dval;
      for (int c = 0; c < 3; c++) begin
        prod_a[c] <= {{SIZE_BITS{1'b0}}, a_pt[c]} * {{CHAN_BITS{1'b0}}, wgt_a};
        prod_b[c] <= {{SIZE_BITS{1'b0}}, b_pt[c]} * {{CHAN_BITS{1'b0}}, wgt_b};
      end
      dval_b <= dval_a;
      // rounded quotient (2*num + d - 1) / (2*d) runs in the channel chains
      for (int c = 0; c < 3; c++) begin
        chan_out[c].rem    <= {sum[c], 1'b0} + DIV_W'(dval_b) - DIV_W'(1);
        chan_out[c].dvs    <= DIV_W'(dval_b) << QUOT_STEPS;
        chan_out[c].quot   <= '0;
        chan_out[c].sel    <= '0;
        chan_out[c].dval   <= dval_b;
        chan_out[c].at_end <= 1'b0;
      end
    end
  end

endmodule
